[sv/jps_pkg.sv]
package jps_pkg;

	// Default data format: signed Q8.24
	localparam int VALUE_WIDTH_DEF   = 32;
	localparam int FRACTION_BITS_DEF = 24;

	// Output queue depth in result words
	localparam int OUT_DEPTH = 16;

	// Width of the configuration register index
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_EW = 2'd0,
		REG_COEF_NS = 2'd1,
		REG_SOURCE  = 2'd2,
		REG_TOL     = 2'd3
	} cfg_reg_t;

	// What one accepted column produces downstream
	typedef struct packed {
		logic pend;   // pending column is emitted
		logic sten;   // pending column gets the stencil update
		logic own;    // this column is emitted as the row's last point
		logic first;  // clear the running maximum before this column
	} item_flags_t;

endpackage

[sv/jps_window.sv]
module jps_window #(
	parameter int VALUE_WIDTH = jps_pkg::VALUE_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  logic [VALUE_WIDTH-1:0]   south,
	input  logic [VALUE_WIDTH-1:0]   center,
	input  logic [VALUE_WIDTH-1:0]   north,
	input  logic                     update_enable,
	input  logic                     first_of_sweep,
	input  logic                     row_end,
	output logic [1:0]               res_count,
	output logic                     valid_s1,
	output jps_pkg::item_flags_t     flags_s1,
	output logic [VALUE_WIDTH:0]     ew_sum_s1,
	output logic [VALUE_WIDTH:0]     ns_sum_s1,
	output logic [VALUE_WIDTH-1:0]   old_s1,
	output logic [VALUE_WIDTH-1:0]   own_s1
);
	import jps_pkg::*;

	localparam int VW = VALUE_WIDTH;

	logic [VW-1:0] prev_center_q;
	logic [VW-1:0] prev_north_q;
	logic [VW-1:0] prev_south_q;
	logic [VW-1:0] prev2_center_q;
	logic          prev_enable_q;
	logic [1:0]    columns_seen_q;
	item_flags_t   flags;

	// Decide what this column releases
	always_comb begin
		flags.pend  = (columns_seen_q != 2'd0);
		flags.sten  = prev_enable_q && (columns_seen_q == 2'd2);
		flags.own   = row_end;
		flags.first = first_of_sweep;
		res_count   = {1'b0, flags.pend} + {1'b0, flags.own};
	end

	// Advance the two-column window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_seen_q <= 2'd0;
			prev_enable_q  <= 1'b0;
		end else if (accept) begin
			prev_enable_q <= update_enable;
			if (row_end) begin
				columns_seen_q <= 2'd0;
			end else if (columns_seen_q != 2'd2) begin
				columns_seen_q <= columns_seen_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prev2_center_q <= prev_center_q;
			prev_center_q  <= center;
			prev_north_q   <= north;
			prev_south_q   <= south;
		end
	end

	// Register neighbour sums for the multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			flags_s1  <= flags;
			ew_sum_s1 <= {center[VW-1], center} + {prev2_center_q[VW-1], prev2_center_q};
			ns_sum_s1 <= {prev_north_q[VW-1], prev_north_q} + {prev_south_q[VW-1], prev_south_q};
			old_s1    <= prev_center_q;
			own_s1    <= center;
		end
	end

endmodule

[sv/jps_arith.sv]
module jps_arith #(
	parameter int VALUE_WIDTH   = jps_pkg::VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = jps_pkg::FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s1,
	input  jps_pkg::item_flags_t       flags_s1,
	input  logic [VALUE_WIDTH:0]       ew_sum_s1,
	input  logic [VALUE_WIDTH:0]       ns_sum_s1,
	input  logic [VALUE_WIDTH-1:0]     old_s1,
	input  logic [VALUE_WIDTH-1:0]     own_s1,
	input  logic [FRACTION_BITS-1:0]   coef_east_west,
	input  logic [FRACTION_BITS-1:0]   coef_north_south,
	input  logic [VALUE_WIDTH-1:0]     source_term,
	output logic                       valid_s4,
	output jps_pkg::item_flags_t       flags_s4,
	output logic [VALUE_WIDTH-1:0]     val_s4,
	output logic [VALUE_WIDTH-2:0]     chg_s4,
	output logic [VALUE_WIDTH-1:0]     own_s4
);
	import jps_pkg::*;

	localparam int VW = VALUE_WIDTH;
	localparam int FB = FRACTION_BITS;
	localparam int PW = VW + FB + 2;   // signed product
	localparam int AW = PW + 1;        // sum of both products
	localparam int SW = AW - FB;       // after dropping the fraction
	localparam int TW = SW + 1;        // after subtracting the source
	localparam logic [AW-1:0] ROUND_HALF = AW'(1) << (FB - 1);

	logic signed [PW-1:0] prod_ew;
	logic signed [PW-1:0] prod_ns;
	logic [PW-1:0]        prod_ew_s2;
	logic [PW-1:0]        prod_ns_s2;
	logic                 valid_s2;
	logic                 valid_s3;
	item_flags_t          flags_s2;
	item_flags_t          flags_s3;
	logic [VW-1:0]        old_s2;
	logic [VW-1:0]        old_s3;
	logic [VW-1:0]        own_s2;
	logic [VW-1:0]        own_s3;
	logic [VW-1:0]        val_s3;
	logic [AW-1:0]        acc;
	logic [SW-1:0]        acc_sh;
	logic [TW-1:0]        diff_src;
	logic [VW-1:0]        sat_val;
	logic [VW-1:0]        next_val;
	logic [VW:0]          delta;
	logic [VW:0]          delta_mag;
	logic [VW-2:0]        next_chg;

	// Weight the neighbour sums
	assign prod_ew = $signed(ew_sum_s1) * $signed({1'b0, coef_east_west});
	assign prod_ns = $signed(ns_sum_s1) * $signed({1'b0, coef_north_south});

	// Round half up, drop the fraction, subtract the source and saturate, or keep the old value if not updated
	always_comb begin
		acc      = {prod_ew_s2[PW-1], prod_ew_s2} + {prod_ns_s2[PW-1], prod_ns_s2} + ROUND_HALF;
		acc_sh   = acc[AW-1:FB];
		diff_src = {acc_sh[SW-1], acc_sh} - {{(TW-VW){source_term[VW-1]}}, source_term};
		if ((&diff_src[TW-1:VW-1]) || !(|diff_src[TW-1:VW-1])) begin
			sat_val = diff_src[VW-1:0];
		end else if (diff_src[TW-1]) begin
			sat_val = {1'b1, {(VW-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(VW-1){1'b1}}};
		end
		next_val = flags_s2.sten ? sat_val : old_s2;
	end

	// Absolute change of the emitted point, clipped
	always_comb begin
		delta     = {val_s3[VW-1], val_s3} - {old_s3[VW-1], old_s3};
		delta_mag = delta[VW] ? (~delta + 1'b1) : delta;
		next_chg  = (|delta_mag[VW:VW-1]) ? {(VW-1){1'b1}} : delta_mag[VW-2:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_ew_s2 <= prod_ew;
		prod_ns_s2 <= prod_ns;
		flags_s2   <= flags_s1;
		old_s2     <= old_s1;
		own_s2     <= own_s1;

		val_s3     <= next_val;
		flags_s3   <= flags_s2;
		old_s3     <= old_s2;
		own_s3     <= own_s2;

		val_s4     <= val_s3;
		chg_s4     <= next_chg;
		flags_s4   <= flags_s3;
		own_s4     <= own_s3;
	end

endmodule

[sv/jps_track.sv]
module jps_track #(
	parameter int VALUE_WIDTH = jps_pkg::VALUE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       valid_s4,
	input  jps_pkg::item_flags_t       flags_s4,
	input  logic [VALUE_WIDTH-1:0]     val_s4,
	input  logic [VALUE_WIDTH-2:0]     chg_s4,
	input  logic [VALUE_WIDTH-1:0]     own_s4,
	input  logic [VALUE_WIDTH-2:0]     tolerance,
	output logic [1:0]                 wr_count,
	output logic [2*VALUE_WIDTH:0]     word_a,
	output logic [2*VALUE_WIDTH:0]     word_b
);
	import jps_pkg::*;

	localparam int VW = VALUE_WIDTH;

	logic [VW-2:0] running_max_q;
	logic [VW-2:0] base_max;
	logic [VW-2:0] new_max;
	logic          conv;
	logic [2*VW:0] word_pend;
	logic [2*VW:0] word_own;

	// Update the sweep maximum; the row-end point never changes it
	always_comb begin
		base_max = flags_s4.first ? '0 : running_max_q;
		new_max  = (flags_s4.pend && (chg_s4 > base_max)) ? chg_s4 : base_max;
		conv     = (new_max < tolerance);
		// word layout from the top: last, converged, max, value
		word_pend = {1'b0, conv, new_max, val_s4};
		word_own  = {1'b1, conv, new_max, own_s4};
		word_a    = flags_s4.pend ? word_pend : word_own;
		word_b    = word_own;
		wr_count  = valid_s4 ? ({1'b0, flags_s4.pend} + {1'b0, flags_s4.own}) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_max_q <= '0;
		end else if (valid_s4) begin
			running_max_q <= new_max;
		end
	end

endmodule

[sv/jps_fifo.sv]
module jps_fifo #(
	parameter int WORD_WIDTH = 2 * jps_pkg::VALUE_WIDTH_DEF + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [1:0]              reserve,
	input  logic [1:0]              wr_count,
	input  logic [WORD_WIDTH-1:0]   word_a,
	input  logic [WORD_WIDTH-1:0]   word_b,
	input  logic                    pop,
	output logic [WORD_WIDTH-1:0]   rd_word,
	output logic                    rd_valid,
	output logic                    space_ok
);
	import jps_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);
	localparam logic [CNT_W-1:0] RESERVE_LIMIT = CNT_W'(OUT_DEPTH - 2);

	logic [WORD_WIDTH-1:0] store_q [OUT_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      committed_q;

	assign rd_word  = store_q[rd_ptr_q];
	assign rd_valid = (fill_q != '0);
	// Admit a column only if both of its possible words have a slot
	assign space_ok = (committed_q <= RESERVE_LIMIT);

	// Write up to two words in order
	always_ff @(posedge clk) begin
		if (wr_count != 2'd0) begin
			store_q[wr_ptr_q] <= word_a;
		end
		if (wr_count == 2'd2) begin
			store_q[wr_ptr_q + PTR_W'(1)] <= word_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			fill_q      <= '0;
			committed_q <= '0;
		end else begin
			wr_ptr_q    <= wr_ptr_q + PTR_W'(wr_count);
			rd_ptr_q    <= rd_ptr_q + PTR_W'(pop);
			fill_q      <= fill_q + CNT_W'(wr_count) - CNT_W'(pop);
			committed_q <= committed_q + CNT_W'(reserve) - CNT_W'(pop);
		end
	end

endmodule

[sv/jacobi_poisson_stencil.sv]
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: south, center, north;
//                                                     tuser: update_enable, first_of_sweep;
//                                                     tlast: row_end
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: new_value, max_change, converged;
//                                                     tlast: last_of_row
// cfg       in         cfg_valid / cfg_ready          cfg_index, cfg_data
//
// One column is accepted per cycle while input ready is high; its words are registered
// through the window, the arithmetic stages and the queue. A row-end column that also
// releases the pending column gives two words, and the output drains one word per cycle
// while m_axis_tready is high, through a 16-word queue. Input ready drops while fewer
// than two queue slots are left free of the words already owed to accepted columns;
// the arithmetic stages themselves never stall. Reset empties the window and the queue,
// clears the sweep maximum and the coefficients and sets the tolerance to 2.
module jacobi_poisson_stencil #(
	parameter int VALUE_WIDTH   = jps_pkg::VALUE_WIDTH_DEF,
	parameter int FRACTION_BITS = jps_pkg::FRACTION_BITS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_axis_tvalid,
	output logic                                         s_axis_tready,
	// south_value, center_value, north_value
	input  logic [((3*VALUE_WIDTH+7)/8)*8-1:0]           s_axis_tdata,
	// update_enable, first_of_sweep
	input  logic [1:0]                                   s_axis_tuser,
	input  logic                                         s_axis_tlast,
	output logic                                         m_axis_tvalid,
	input  logic                                         m_axis_tready,
	// new_value, max_change, converged
	output logic [((2*VALUE_WIDTH+7)/8)*8-1:0]           m_axis_tdata,
	output logic                                         m_axis_tlast,
	input  logic                                         cfg_valid,
	output logic                                         cfg_ready,
	input  logic [jps_pkg::CFG_IDX_W-1:0]                cfg_index,
	input  logic [VALUE_WIDTH-1:0]                       cfg_data
);
	import jps_pkg::*;

	localparam int VW    = VALUE_WIDTH;
	localparam int FB    = FRACTION_BITS;
	localparam int OUT_W = ((2*VW+7)/8)*8;
	localparam int WW    = 2*VW + 1;

	logic [FB-1:0]  coef_ew_q;
	logic [FB-1:0]  coef_ns_q;
	logic [VW-1:0]  source_q;
	logic [VW-2:0]  tolerance_q;

	logic           accept;
	logic [1:0]     res_count;
	logic           valid_s1;
	item_flags_t    flags_s1;
	logic [VW:0]    ew_sum_s1;
	logic [VW:0]    ns_sum_s1;
	logic [VW-1:0]  old_s1;
	logic [VW-1:0]  own_s1;
	logic           valid_s4;
	item_flags_t    flags_s4;
	logic [VW-1:0]  val_s4;
	logic [VW-2:0]  chg_s4;
	logic [VW-1:0]  own_s4;
	logic [1:0]     wr_count;
	logic [WW-1:0]  word_a;
	logic [WW-1:0]  word_b;
	logic [WW-1:0]  rd_word;
	logic           space_ok;

	// Hold configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_ew_q   <= '0;
			coef_ns_q   <= '0;
			source_q    <= '0;
			tolerance_q <= (VW-1)'(2);
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_COEF_EW: coef_ew_q   <= cfg_data[FB-1:0];
				REG_COEF_NS: coef_ns_q   <= cfg_data[FB-1:0];
				REG_SOURCE:  source_q    <= cfg_data;
				REG_TOL:     tolerance_q <= cfg_data[VW-2:0];
				default: begin
				end
			endcase
		end
	end

	assign s_axis_tready = space_ok;
	assign accept        = s_axis_tvalid && s_axis_tready;

	jps_window #(
		.VALUE_WIDTH(VW)
	) u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.south          (s_axis_tdata[VW-1:0]),
		.center         (s_axis_tdata[2*VW-1:VW]),
		.north          (s_axis_tdata[3*VW-1:2*VW]),
		.update_enable  (s_axis_tuser[0]),
		.first_of_sweep (s_axis_tuser[1]),
		.row_end        (s_axis_tlast),
		.res_count      (res_count),
		.valid_s1       (valid_s1),
		.flags_s1       (flags_s1),
		.ew_sum_s1      (ew_sum_s1),
		.ns_sum_s1      (ns_sum_s1),
		.old_s1         (old_s1),
		.own_s1         (own_s1)
	);

	jps_arith #(
		.VALUE_WIDTH   (VW),
		.FRACTION_BITS (FB)
	) u_arith (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s1         (valid_s1),
		.flags_s1         (flags_s1),
		.ew_sum_s1        (ew_sum_s1),
		.ns_sum_s1        (ns_sum_s1),
		.old_s1           (old_s1),
		.own_s1           (own_s1),
		.coef_east_west   (coef_ew_q),
		.coef_north_south (coef_ns_q),
		.source_term      (source_q),
		.valid_s4         (valid_s4),
		.flags_s4         (flags_s4),
		.val_s4           (val_s4),
		.chg_s4           (chg_s4),
		.own_s4           (own_s4)
	);

	jps_track #(
		.VALUE_WIDTH(VW)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s4  (valid_s4),
		.flags_s4  (flags_s4),
		.val_s4    (val_s4),
		.chg_s4    (chg_s4),
		.own_s4    (own_s4),
		.tolerance (tolerance_q),
		.wr_count  (wr_count),
		.word_a    (word_a),
		.word_b    (word_b)
	);

	jps_fifo #(
		.WORD_WIDTH(WW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.reserve  (accept ? res_count : 2'd0),
		.wr_count (wr_count),
		.word_a   (word_a),
		.word_b   (word_b),
		.pop      (m_axis_tvalid && m_axis_tready),
		.rd_word  (rd_word),
		.rd_valid (m_axis_tvalid),
		.space_ok (space_ok)
	);

	// Pack the result word; padding bits read as zero
	assign m_axis_tdata = OUT_W'(rd_word[WW-2:0]);
	assign m_axis_tlast = rd_word[WW-1];

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
	import jps_pkg::*;

	localparam int VW          = VALUE_WIDTH_DEF;
	localparam int FW          = FRACTION_BITS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 165;
	localparam longint VMAX    = (longint'(1) <<< (VW - 1)) - 1;
	localparam longint VMIN    = -(longint'(1) <<< (VW - 1));

	typedef struct {
		logic [VW-1:0] south;
		logic [VW-1:0] center;
		logic [VW-1:0] north;
		logic          en;
		logic          first;
		logic          rend;
	} column_t;

	typedef struct {
		logic [VW-1:0] value;
		logic [VW-2:0] peak;
		logic          conv;
		logic          last;
	} word_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	// south_value, center_value, north_value
	logic [3*VW-1:0]           s_axis_tdata;
	// update_enable, first_of_sweep
	logic [1:0]                s_axis_tuser;
	logic                      s_axis_tlast;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	// new_value, max_change, converged
	logic [2*VW-1:0]           m_axis_tdata;
	logic                      m_axis_tlast;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [VW-1:0]             cfg_data;

	jacobi_poisson_stencil u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Register copies, reset values
	logic [FW-1:0]        coef_ew  = '0;
	logic [FW-1:0]        coef_ns  = '0;
	logic signed [VW-1:0] src_term = '0;
	logic [VW-2:0]        tol_reg  = (VW-1)'(2);

	// Column window and sweep maximum
	logic [VW-1:0] win_center = '0;
	logic [VW-1:0] win_north  = '0;
	logic [VW-1:0] win_south  = '0;
	logic [VW-1:0] win_west   = '0;
	logic          win_en     = 1'b0;
	int            win_cols   = 0;
	logic [VW-2:0] sweep_max  = '0;

	column_t column_q[$];
	word_t   expected_words[$];
	bit      col_offered    = 1'b0;
	bit      last_rend      = 1'b1;
	int      send_idle_pct  = 0;
	int      recv_stall_pct = 0;
	int      hold_req       = 0;
	int      hold_left      = 0;
	int      fail_count     = 0;
	int      cycle_count    = 0;
	int      columns_queued = 0;
	int      send_plan[PHASES] = '{0, 65, 0, 33, 0, 65, 0, 33};
	int      recv_plan[PHASES] = '{0, 0, 65, 33, 0, 0, 65, 33};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Relaxed value of the pending column, given its east neighbour
	function automatic logic [VW-1:0] relax_point(logic [VW-1:0] east);
		longint ew_sum, ns_sum, acc;
		ew_sum = longint'($signed(east)) + longint'($signed(win_west));
		ns_sum = longint'($signed(win_north)) + longint'($signed(win_south));
		acc = ew_sum * longint'(coef_ew) + ns_sum * longint'(coef_ns)
			+ (longint'(1) <<< (FW - 1));
		acc = (acc >>> FW) - longint'(src_term);
		if (acc > VMAX)
			acc = VMAX;
		else if (acc < VMIN)
			acc = VMIN;
		return acc[VW-1:0];
	endfunction

	// Fold the change into the sweep maximum and queue the expected word
	function automatic void log_word(logic [VW-1:0] value, logic [VW-1:0] old, logic last);
		longint d;
		word_t  w;
		d = longint'($signed(value)) - longint'($signed(old));
		if (d < 0)
			d = -d;
		if (d > VMAX)
			d = VMAX;
		if (d > longint'(sweep_max))
			sweep_max = d[VW-2:0];
		w.value = value;
		w.peak  = sweep_max;
		w.conv  = sweep_max < tol_reg;
		w.last  = last;
		expected_words = {expected_words, w};
	endfunction

	// Advance the window by one accepted column
	function automatic void stencil_column(column_t c);
		logic [VW-1:0] v;
		if (c.first)
			sweep_max = '0;
		if (win_cols != 0) begin
			v = (win_en && win_cols == 2) ? relax_point(c.center) : win_center;
			log_word(v, win_center, 1'b0);
		end
		win_west   = win_center;
		win_center = c.center;
		win_north  = c.north;
		win_south  = c.south;
		win_en     = c.en;
		if (win_cols < 2)
			win_cols++;
		if (c.rend) begin
			log_word(c.center, c.center, 1'b1);
			win_cols = 0;
		end
	endfunction

	task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
		if (fail_count < 40)
			$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	function automatic void push_col(logic [VW-1:0] s, logic [VW-1:0] c, logic [VW-1:0] n,
			logic en, logic first, logic rend);
		column_t col;
		col.south  = s;
		col.center = c;
		col.north  = n;
		col.en     = en;
		col.first  = first;
		col.rend   = rend;
		column_q = {column_q, col};
		last_rend = rend;
		columns_queued++;
	endfunction

	// Mostly a smooth field around the row base, now and then an extreme or noise
	function automatic logic [VW-1:0] pick_value(logic [VW-1:0] base);
		case ($urandom_range(0, 15))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return 32'h0000_0000;
		3: return 32'hFFFF_FFFF;
		4, 5, 6: return $urandom;
		default: return base + $urandom_range(0, 8191) - 4096;
		endcase
	endfunction

	function automatic void push_row(int len, bit sweep_start, bit noisy);
		logic [VW-1:0] base;
		logic          en, first, rend;
		base = $urandom_range(0, 32'h03FF_FFFF) - 32'h0200_0000;
		for (int i = 0; i < len; i++) begin
			if (noisy) begin
				en    = 1'($urandom_range(0, 1));
				first = $urandom_range(0, 7) == 0;
				rend  = $urandom_range(0, 3) == 0;
			end else begin
				en    = (i > 0 && i < len - 1) ? ($urandom_range(0, 9) != 0)
					: ($urandom_range(0, 9) == 0);
				first = (i == 0) && sweep_start;
				rend  = i == len - 1;
			end
			push_col(pick_value(base), pick_value(base), pick_value(base), en, first, rend);
		end
	endfunction

	function automatic void push_random_rows(int count);
		int stop;
		int len;
		stop = columns_queued + count;
		while (columns_queued < stop) begin
			case ($urandom_range(0, 9))
			0: len = 1;
			1: len = 2;
			default: len = $urandom_range(3, 10);
			endcase
			push_row(len, $urandom_range(0, 3) == 0, $urandom_range(0, 9) == 0);
		end
		// leave the window empty so that register writes never meet a pending column
		if (!last_rend)
			push_col($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)), 1'b0, 1'b1);
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [VW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
		REG_COEF_EW: coef_ew  = data[FW-1:0];
		REG_COEF_NS: coef_ns  = data[FW-1:0];
		REG_SOURCE:  src_term = data;
		REG_TOL:     tol_reg  = data[VW-2:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_regs(logic [VW-1:0] ew, logic [VW-1:0] ns, logic [VW-1:0] src,
			logic [VW-1:0] tol);
		write_reg(REG_COEF_EW, ew);
		write_reg(REG_COEF_NS, ns);
		write_reg(REG_SOURCE, src);
		write_reg(REG_TOL, tol);
	endtask

	// Wait until every queued column is taken and every word has come, then settle
	task automatic drain(int settle);
		while (column_q.size() != 0 || col_offered || expected_words.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Column driver: hold an offered column until it is taken
	always @(negedge clk) begin
		if (!col_offered) begin
			if (arst_n && column_q.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {column_q[0].north, column_q[0].center, column_q[0].south};
				s_axis_tuser  <= {column_q[0].first, column_q[0].en};
				s_axis_tlast  <= column_q[0].rend;
				col_offered = 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver with random stalls and the long hold-off
	always @(negedge clk) begin
		m_axis_tready <= (hold_left == 0) && ($urandom_range(1, 100) > recv_stall_pct);
	end

	// Count down the receiver hold-off
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end else if (hold_left != 0) begin
			hold_left--;
		end
	end

	// Check result words, then predict from the accepted column
	always @(posedge clk) begin
		word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("word with none expected", m_axis_tdata[VW-1:0], '0);
			end else begin
				want = expected_words.pop_front();
				if (m_axis_tdata[VW-1:0] !== want.value)
					report_mismatch("new_value", m_axis_tdata[VW-1:0], want.value);
				if (m_axis_tdata[2*VW-2:VW] !== want.peak)
					report_mismatch("max_change", VW'(m_axis_tdata[2*VW-2:VW]),
						VW'(want.peak));
				if (m_axis_tdata[2*VW-1] !== want.conv)
					report_mismatch("converged", VW'(m_axis_tdata[2*VW-1]), VW'(want.conv));
				if (m_axis_tlast !== want.last)
					report_mismatch("last_of_row", VW'(m_axis_tlast), VW'(want.last));
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			stencil_column(column_q.pop_front());
			col_offered = 1'b0;
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[jacobi_poisson_stencil] ERROR");
			$finish;
		end
	end

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		s_axis_tlast  = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_COEF_EW;
		cfg_data      = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values: zero coefficients relax an interior point to zero, tolerance 2
		push_col(32'h0000_0005, 32'h0100_0000, 32'h0000_0007, 1'b1, 1'b1, 1'b0);
		push_col(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 1'b1, 1'b0, 1'b0);
		push_col(32'h0000_0003, 32'h0000_0002, 32'h0000_0004, 1'b1, 1'b0, 1'b1);
		drain(8);

		// Quarter weights; upper bits of the narrow registers must be dropped
		program_regs(32'hAB40_0000, 32'h5540_0000, 32'h0000_0000, 32'h8000_0100);
		// one-column row
		push_col(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1);
		// two-column row: no point has both neighbours
		push_col(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
		push_col(32'h0000_0000, 32'h0000_0002, 32'h0000_0000, 1'b1, 1'b0, 1'b1);
		// exact half rounds up
		push_col(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
		push_col(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
		push_col(32'h0000_0000, 32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
		// negative half rounds towards plus infinity
		push_col(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b0);
		push_col(32'h0000_0000, 32'h0000_0005, 32'h0000_0000, 1'b1, 1'b0, 1'b0);
		push_col(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b1);
		// extremes, sweep restart inside the row
		push_col(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
		push_col(32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);
		push_col(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
		push_col(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 1'b0);
		push_col(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 1'b1);
		// interior points not flagged pass through
		push_col(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1'b0, 1'b0, 1'b0);
		push_col(32'h0000_0004, 32'h0000_0005, 32'h0000_0006, 1'b0, 1'b0, 1'b0);
		push_col(32'h0000_0007, 32'h0000_0008, 32'h0000_0009, 1'b0, 1'b0, 1'b1);
		drain(8);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: program_regs(32'h0040_0000, 32'h0040_0000, 32'h0000_0000, 32'h0000_0002);
			1: program_regs(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
			2: program_regs(32'h0000_0000, 32'hFF00_0000, 32'h7FFF_FFFF, 32'h0000_0000);
			4: program_regs(32'h0040_0000, 32'h0020_0000, $urandom_range(0, 4095),
				32'h0000_0100);
			7: program_regs(32'h003F_FFFF, 32'h0040_0001, 32'hFFFF_F000, 32'hFFFF_FFFF);
			default: program_regs($urandom, $urandom, $urandom, $urandom);
			endcase
			@(posedge clk);
			send_idle_pct  = send_plan[p];
			recv_stall_pct = recv_plan[p];
			if (p == 2) begin
				// receiver holds off while the sender keeps offering
				send_idle_pct = 0;
				push_random_rows(PHASE_ITEMS);
				@(negedge clk);
				hold_req = 300;
			end else if (p == 4) begin
				// sender pauses until every word is back
				push_random_rows(PHASE_ITEMS / 2);
				drain(0);
				push_random_rows(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				push_random_rows(PHASE_ITEMS);
			end
			drain(8);
		end

		drain(20);
		if (fail_count == 0)
			$display("[jacobi_poisson_stencil] OK");
		else
			$display("[jacobi_poisson_stencil] ERROR");
		$finish;
	end

endmodule
